[rtl/core/sdbls_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and elaboration-time tables for the spectrum dB level smoother.
// No dependencies; every other file of the block takes names from here by scope.
package sdbls_pkg;

    // Field widths
    localparam int BIN_W    = 10;
    localparam int MAG_W    = 24;
    localparam int LEVEL_W  = 16;
    localparam int POS_W    = 5;
    localparam int FRAC_W   = 8;
    localparam int LOG2_W   = POS_W + FRAC_W;
    localparam int NEG_W    = 13;
    localparam int SLOPE_W  = 15;
    localparam int DBPROD_W = NEG_W + SLOPE_W;
    localparam int NUM_W    = 21;
    localparam int RECIP_W  = 22;
    localparam int QPROD_W  = NUM_W + RECIP_W;
    localparam int ACC_W    = 2 * LEVEL_W + 1;

    // Transform size and fixed reference of full scale
    localparam int unsigned FFT_POINTS  = 2048;
    localparam int unsigned STORE_DEPTH = 1024;
    localparam int unsigned MAG_FRAC_Q8 = 12 * 256;

    // dB scaling
    localparam int unsigned DB_FLOOR_Q8     = 25600;
    localparam int unsigned DB_PER_LOG2_Q12 = 24660;
    localparam int unsigned DB_ROUND        = 2048;
    localparam int unsigned DB_SHIFT        = 12;

    // Level mapping: level = floor((64*e + 25) / 50), e = 25600 - d
    localparam int unsigned LEVEL_ONE   = 32768;
    localparam int unsigned LEVEL_BIAS  = 25;
    localparam int unsigned LEVEL_DIV   = 50;
    localparam int unsigned RECIP_SHIFT = 27;
    localparam int unsigned RECIP_K     = ((1 << RECIP_SHIFT) + LEVEL_DIV - 1) / LEVEL_DIV;

    // Smoothing coefficients, Q16
    localparam int unsigned COEF_OLD   = 55706;
    localparam int unsigned COEF_NEW   = 9830;
    localparam int unsigned ROUND_HALF = 32768;

    typedef logic [255:0][FRAC_W-1:0] frac_tbl_t;

    // Stage 3 result: attenuation input to the dB scaler
    typedef struct packed {
        logic             valid;
        logic [BIN_W-1:0] bin;
        logic             zero;
        logic [NEG_W-1:0] neg;
    } att_stage_t;

    // Store read request, issued one stage ahead of the smoother
    typedef struct packed {
        logic             valid;
        logic [BIN_W-1:0] bin;
    } rd_req_t;

    // Stage 6 result: instant level
    typedef struct packed {
        logic               valid;
        logic [BIN_W-1:0]   bin;
        logic [LEVEL_W-1:0] level;
    } lvl_stage_t;

    // floor(256*log2(1+idx/256)) by repeated squaring, msb first
    function automatic logic [FRAC_W-1:0] frac_entry(input int unsigned idx);
        logic [63:0]       y;
        logic [FRAC_W-1:0] bits;
        y    = 64'(256 + (idx & 255)) << 22;
        bits = '0;
        for (int k = 0; k < FRAC_W; k++)
        begin
            y    = (y * y) >> 30;
            bits = {bits[FRAC_W-2:0], 1'b0};
            if (y >= 64'h0000_0000_8000_0000)
            begin
                bits[0] = 1'b1;
                y       = y >> 1;
            end
        end
        return bits;
    endfunction

    function automatic frac_tbl_t build_frac_tbl();
        frac_tbl_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = frac_entry(i);
        end
        return t;
    endfunction

    localparam frac_tbl_t LOG2_FRAC = build_frac_tbl();

    // log2 in Q8.8 of a nonzero constant
    function automatic int unsigned log2_q8_const(input int unsigned x);
        int unsigned p;
        int unsigned f;
        p = 0;
        for (int i = 0; i < 32; i++)
        begin
            if (x[i])
                p = i;
        end
        if (p >= 8)
            f = (x >> (p - 8)) & 255;
        else
            f = (x << (8 - p)) & 255;
        return p * 256 + int'(frac_entry(f));
    endfunction

    localparam int unsigned LOG2_OFFSET = MAG_FRAC_Q8 + log2_q8_const(FFT_POINTS);

endpackage

[rtl/core/sdbls_in_if.sv]
`timescale 1ns / 1ps
// Request channel carrying one bin magnitude and its bin index.
// Depends on sdbls_pkg for field widths.
interface sdbls_in_if;
    logic                         valid;
    logic                         ready;
    logic [sdbls_pkg::BIN_W-1:0]  bin_index;
    logic [sdbls_pkg::MAG_W-1:0]  magnitude;

    modport source (output valid, bin_index, magnitude, input ready);
    modport sink   (input valid, bin_index, magnitude, output ready);
endinterface

[rtl/core/sdbls_out_if.sv]
`timescale 1ns / 1ps
// Result channel carrying the bin index, instant level and smoothed level.
// Depends on sdbls_pkg for field widths.
interface sdbls_out_if;
    logic                          valid;
    logic                          ready;
    logic [sdbls_pkg::BIN_W-1:0]   out_bin;
    logic [sdbls_pkg::LEVEL_W-1:0] level;
    logic [sdbls_pkg::LEVEL_W-1:0] smoothed_level;

    modport source (output valid, out_bin, level, smoothed_level, input ready);
    modport sink   (input valid, out_bin, level, smoothed_level, output ready);
endinterface

[rtl/core/sdbls_log2.sv]
`timescale 1ns / 1ps
// Stages 1 to 3: input register, leading-one detect, log2 table and offset to full scale.
// Depends on sdbls_pkg.
module sdbls_log2 (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          accept,
    input  logic [sdbls_pkg::BIN_W-1:0]   bin_index,
    input  logic [sdbls_pkg::MAG_W-1:0]   magnitude,
    output sdbls_pkg::att_stage_t         att
);

    localparam int MW = sdbls_pkg::MAG_W;
    localparam int PW = sdbls_pkg::POS_W;
    localparam int FW = sdbls_pkg::FRAC_W;
    localparam int LW = sdbls_pkg::LOG2_W + 2;

    // Stage 1
    logic                        s1_valid_reg;
    logic [sdbls_pkg::BIN_W-1:0] s1_bin_reg;
    logic [MW-1:0]               s1_mag_reg;

    // Stage 2
    logic                        s2_valid_reg;
    logic [sdbls_pkg::BIN_W-1:0] s2_bin_reg;
    logic                        s2_zero_reg;
    logic [PW-1:0]               s2_pos_reg;
    logic [FW-1:0]               s2_frac_reg;
    logic [PW-1:0]               s2_pos_next;
    logic [FW-1:0]               s2_frac_next;
    logic [MW-1:0]               norm;

    // Stage 3
    logic                        s3_valid_reg;
    logic [sdbls_pkg::BIN_W-1:0] s3_bin_reg;
    logic                        s3_zero_reg;
    logic [sdbls_pkg::NEG_W-1:0] s3_neg_reg;
    logic [sdbls_pkg::NEG_W-1:0] s3_neg_next;
    logic [sdbls_pkg::LOG2_W-1:0] lm;
    logic signed [LW-1:0]        lval;

    // Find the leading one and the eight bits below it
    always_comb
    begin
        s2_pos_next = '0;
        for (int i = 0; i < MW; i++)
        begin
            if (s1_mag_reg[i])
                s2_pos_next = PW'(i);
        end
        norm         = s1_mag_reg << (PW'(MW - 1) - s2_pos_next);
        s2_frac_next = norm[MW-2 -: FW];
    end

    // Look up the fraction and subtract full scale
    always_comb
    begin
        lm   = {s2_pos_reg, sdbls_pkg::LOG2_FRAC[s2_frac_reg]};
        lval = $signed({2'b00, lm}) - $signed(LW'(sdbls_pkg::LOG2_OFFSET));
        if (lval[LW-1])
            s3_neg_next = sdbls_pkg::NEG_W'(-lval);
        else
            s3_neg_next = '0;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (accept)
            begin
                s1_bin_reg <= bin_index;
                s1_mag_reg <= magnitude;
            end
            s2_bin_reg  <= s1_bin_reg;
            s2_zero_reg <= (s1_mag_reg == '0);
            s2_pos_reg  <= s2_pos_next;
            s2_frac_reg <= s2_frac_next;
            s3_bin_reg  <= s2_bin_reg;
            s3_zero_reg <= s2_zero_reg;
            s3_neg_reg  <= s3_neg_next;
        end
    end

    assign att.valid = s3_valid_reg;
    assign att.bin   = s3_bin_reg;
    assign att.zero  = s3_zero_reg;
    assign att.neg   = s3_neg_reg;

endmodule

[rtl/core/sdbls_level.sv]
`timescale 1ns / 1ps
// Stages 4 to 6: scale log2 offset to dB, clamp, and map to a Q1.15 level.
// Depends on sdbls_pkg.
module sdbls_level (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  sdbls_pkg::att_stage_t  att,
    output sdbls_pkg::rd_req_t     rd_req,
    output sdbls_pkg::lvl_stage_t  lvl
);

    localparam int DW = sdbls_pkg::DBPROD_W;
    localparam int NW = sdbls_pkg::NUM_W;
    localparam int QW = sdbls_pkg::QPROD_W;
    localparam int EW = sdbls_pkg::SLOPE_W;
    localparam int DB_SH_W = sdbls_pkg::DB_SHIFT;

    // Stage 4
    logic                        s4_valid_reg;
    logic [sdbls_pkg::BIN_W-1:0] s4_bin_reg;
    logic                        s4_zero_reg;
    logic [DW-1:0]               s4_prod_reg;

    // Stage 5
    logic                        s5_valid_reg;
    logic [sdbls_pkg::BIN_W-1:0] s5_bin_reg;
    logic                        s5_zero_reg;
    logic [NW-1:0]               s5_num_reg;
    logic [NW-1:0]               s5_num_next;
    logic [DW:0]                 db_round;
    logic [DW-DB_SH_W-1:0]       db_raw;
    logic [EW-1:0]               db_att;
    logic [EW-1:0]               db_left;

    // Stage 6
    logic                           s6_valid_reg;
    logic [sdbls_pkg::BIN_W-1:0]    s6_bin_reg;
    logic [sdbls_pkg::LEVEL_W-1:0]  s6_level_reg;
    logic [sdbls_pkg::LEVEL_W-1:0]  s6_level_next;
    logic [QW-1:0]                  qprod;

    // Round the dB product, saturate at the floor, build the numerator
    always_comb
    begin
        db_round = {1'b0, s4_prod_reg} + (DW + 1)'(sdbls_pkg::DB_ROUND);
        db_raw   = db_round[DW-1:DB_SH_W];
        if (db_round[DW] || (db_raw > (DW - DB_SH_W)'(sdbls_pkg::DB_FLOOR_Q8)))
            db_att = EW'(sdbls_pkg::DB_FLOOR_Q8);
        else
            db_att = db_raw[EW-1:0];
        db_left     = EW'(sdbls_pkg::DB_FLOOR_Q8) - db_att;
        s5_num_next = {db_left, 6'd0} + NW'(sdbls_pkg::LEVEL_BIAS);
    end

    // Divide by fifty through the reciprocal; zero magnitude maps to zero
    always_comb
    begin
        qprod = QW'(s5_num_reg) * QW'(sdbls_pkg::RECIP_K);
        if (s5_zero_reg)
            s6_level_next = '0;
        else
            s6_level_next = qprod[sdbls_pkg::RECIP_SHIFT +: sdbls_pkg::LEVEL_W];
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_valid_reg <= att.valid;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_bin_reg   <= att.bin;
            s4_zero_reg  <= att.zero;
            s4_prod_reg  <= DW'(att.neg) * DW'(sdbls_pkg::DB_PER_LOG2_Q12);
            s5_bin_reg   <= s4_bin_reg;
            s5_zero_reg  <= s4_zero_reg;
            s5_num_reg   <= s5_num_next;
            s6_bin_reg   <= s5_bin_reg;
            s6_level_reg <= s6_level_next;
        end
    end

    assign rd_req.valid = s5_valid_reg;
    assign rd_req.bin   = s5_bin_reg;
    assign lvl.valid    = s6_valid_reg;
    assign lvl.bin      = s6_bin_reg;
    assign lvl.level    = s6_level_reg;

endmodule

[rtl/core/sdbls_smooth.sv]
`timescale 1ns / 1ps
// Per-bin smoothing store with clearing pass, forward path and the result register.
// Depends on sdbls_pkg.
module sdbls_smooth (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  sdbls_pkg::rd_req_t            rd_req,
    input  sdbls_pkg::lvl_stage_t         lvl,
    output logic                          clr_busy,
    output logic                          out_valid,
    output logic [sdbls_pkg::BIN_W-1:0]   out_bin,
    output logic [sdbls_pkg::LEVEL_W-1:0] out_level,
    output logic [sdbls_pkg::LEVEL_W-1:0] out_smoothed
);

    localparam int LW = sdbls_pkg::LEVEL_W;
    localparam int BW = sdbls_pkg::BIN_W;
    localparam int AW = sdbls_pkg::ACC_W;

    logic [LW-1:0] store_mem [sdbls_pkg::STORE_DEPTH];

    logic          clr_busy_reg;
    logic [BW-1:0] clr_cnt_reg;

    logic [LW-1:0] rd_data_reg;
    logic          fwd_reg;
    logic [LW-1:0] fwd_data_reg;

    logic          out_valid_reg;
    logic [BW-1:0] out_bin_reg;
    logic [LW-1:0] out_level_reg;
    logic [LW-1:0] out_smoothed_reg;

    logic [LW-1:0] old_val;
    logic [AW-1:0] acc;
    logic [LW:0]   sm_wide;
    logic [LW-1:0] sm_next;
    logic          wr_en;
    logic [BW-1:0] wr_addr;
    logic [LW-1:0] wr_data;

    // Blend old and new level, 0.85 / 0.15 in Q16
    always_comb
    begin
        old_val = fwd_reg ? fwd_data_reg : rd_data_reg;
        acc     = AW'(old_val) * AW'(sdbls_pkg::COEF_OLD)
                + AW'(lvl.level) * AW'(sdbls_pkg::COEF_NEW)
                + AW'(sdbls_pkg::ROUND_HALF);
        sm_wide = acc[AW-1 -: LW + 1];
        if (sm_wide > (LW + 1)'(sdbls_pkg::LEVEL_ONE))
            sm_next = LW'(sdbls_pkg::LEVEL_ONE);
        else
            sm_next = sm_wide[LW-1:0];
    end

    // Select store write: clearing pass first, then updates
    always_comb
    begin
        wr_en   = clr_busy_reg || (adv && lvl.valid);
        wr_addr = clr_busy_reg ? clr_cnt_reg : lvl.bin;
        wr_data = clr_busy_reg ? '0 : sm_next;
    end

    // Sweep the store to zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == BW'(sdbls_pkg::STORE_DEPTH - 1))
                clr_busy_reg <= 1'b0;
        end
    end

    // Store write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_addr] <= wr_data;
    end

    // Store read port; forward the update that lands on the same edge
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_data_reg  <= store_mem[rd_req.bin];
            fwd_reg      <= rd_req.valid && lvl.valid && (lvl.bin == rd_req.bin);
            fwd_data_reg <= sm_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= lvl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && lvl.valid)
        begin
            out_bin_reg      <= lvl.bin;
            out_level_reg    <= lvl.level;
            out_smoothed_reg <= sm_next;
        end
    end

    assign clr_busy     = clr_busy_reg;
    assign out_valid    = out_valid_reg;
    assign out_bin      = out_bin_reg;
    assign out_level    = out_level_reg;
    assign out_smoothed = out_smoothed_reg;

endmodule

[rtl/core/spectrum_db_level_smoother_unit.sv]
`timescale 1ns / 1ps
// Top level of the spectrum dB level smoother.
// Depends on sdbls_pkg, sdbls_in_if, sdbls_out_if, sdbls_log2, sdbls_level, sdbls_smooth.
//
// Usage:
//   bin_req   (sink)  : one request per FFT bin, bin_index and Q12.12 magnitude.
//   level_req (source): out_bin, instant Q1.15 level and the updated smoothed
//                       level of that bin; one result per request, in order.
//   Throughput: one request per cycle while the pipeline is not stalled. The
//   request is registered on the accepting edge and then passes the rest of
//   the three log2 stages, three dB/level stages and the result register;
//   the store read runs beside the last level stage.
//   Reset: after rst_n rises, a clearing pass writes the 1024-entry smoothed
//   store to zero, one entry a cycle; bin_req.ready stays low until the pass
//   is done.
//   Stall: when level_req holds a result that is not taken, the whole pipeline
//   holds and bin_req.ready drops; no request is lost or repeated. A request
//   for a bin still in flight sees that bin's latest smoothed value.
module spectrum_db_level_smoother_unit (
    input  logic         clk,
    input  logic         rst_n,
    sdbls_in_if.sink     bin_req,
    sdbls_out_if.source  level_req
);

    logic                  adv;
    logic                  accept;
    logic                  clr_busy;
    sdbls_pkg::att_stage_t att;
    sdbls_pkg::rd_req_t    rd_req;
    sdbls_pkg::lvl_stage_t lvl;

    // Advance whenever the result register is free or being taken
    assign adv           = !level_req.valid || level_req.ready;
    assign bin_req.ready = adv && !clr_busy;
    assign accept        = bin_req.valid && bin_req.ready;

    sdbls_log2 u_log2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .accept    (accept),
        .bin_index (bin_req.bin_index),
        .magnitude (bin_req.magnitude),
        .att       (att)
    );

    sdbls_level u_level (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .att    (att),
        .rd_req (rd_req),
        .lvl    (lvl)
    );

    sdbls_smooth u_smooth (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .rd_req       (rd_req),
        .lvl          (lvl),
        .clr_busy     (clr_busy),
        .out_valid    (level_req.valid),
        .out_bin      (level_req.out_bin),
        .out_level    (level_req.level),
        .out_smoothed (level_req.smoothed_level)
    );

    // No result may leave while the store is still being cleared
    a_no_result_in_clear : assert property (
        @(posedge clk) disable iff (!rst_n)
        clr_busy |-> !level_req.valid
    ) else $error("result presented during store clearing pass");

    // Both levels stay within Q1.15 full scale
    a_level_range : assert property (
        @(posedge clk) disable iff (!rst_n)
        level_req.valid |-> (level_req.level <= 16'(sdbls_pkg::LEVEL_ONE))
                         && (level_req.smoothed_level <= 16'(sdbls_pkg::LEVEL_ONE))
    ) else $error("level above full scale");

    // The last level stage holds while the result waits
    a_stall_holds_stage : assert property (
        @(posedge clk) disable iff (!rst_n)
        (level_req.valid && !level_req.ready) |=> $stable(lvl)
    ) else $error("last stage moved while result stalled");

endmodule

[tb/sdbls_level_tracker_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard for the spectrum dB level smoother bench: predicts the instant and
// smoothed level of every accepted bin request and checks each result in order.
// Depends on sdbls_pkg for field widths, store depth and the transform size.
package sdbls_level_tracker_pkg;
    import sdbls_pkg::*;

    // dB floor (100 dB in Q8.8), dB per octave in Q12, unity level, Q16 weights
    localparam longint FLOOR_DB_Q8   = 25600;
    localparam longint DB_STEP_Q12   = 24660;
    localparam longint FULL_LEVEL    = 32768;
    localparam longint OLD_WEIGHT    = 55706;
    localparam longint NEW_WEIGHT    = 9830;
    localparam int     MAG_FRAC_BITS = 12;
    localparam int     REPORT_LIMIT  = 10;

    typedef struct {
        logic [BIN_W-1:0]   bin;
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] smoothed;
    } level_result_t;

    class level_tracker;
        logic [LEVEL_W-1:0] smoothed_mem [STORE_DEPTH];
        int                 frac_lut [256];
        int                 ref_log2;
        level_result_t      pending_levels [$];
        int                 mismatches;

        function new();
            bit [63:0] y;
            int        bits;
            // Build the log2 fraction table by repeated squaring, msb first
            for (int i = 0; i < 256; i++)
            begin
                y    = 64'(256 + i) << 22;
                bits = 0;
                for (int k = 0; k < 8; k++)
                begin
                    y    = (y * y) >> 30;
                    bits = bits << 1;
                    if (y >= 64'h8000_0000)
                    begin
                        bits = bits | 1;
                        y    = y >> 1;
                    end
                end
                frac_lut[i] = bits;
            end
            foreach (smoothed_mem[i])
                smoothed_mem[i] = '0;
            mismatches = 0;
            ref_log2   = log2_q8(32'(FFT_POINTS));
        endfunction

        // Leading-one position plus table fraction, Q8.8
        function int log2_q8(bit [31:0] x);
            int        p;
            bit [31:0] f;
            p = 31;
            while (p > 0 && !x[p])
                p--;
            if (p >= 8)
                f = (x >> (p - 8)) & 32'hFF;
            else
                f = (x << (8 - p)) & 32'hFF;
            return p * 256 + frac_lut[f];
        endfunction

        // Map a Q12.12 magnitude to a Q1.15 level over the 100 dB span
        function longint level_of(logic [MAG_W-1:0] mag);
            int     excess;
            longint atten;
            if (mag == '0)
                return 0;
            excess = log2_q8(32'(mag)) - MAG_FRAC_BITS * 256 - ref_log2;
            if (excess >= 0)
                atten = 0;
            else
            begin
                atten = (longint'(-excess) * DB_STEP_Q12 + 2048) >>> 12;
                if (atten > FLOOR_DB_Q8)
                    atten = FLOOR_DB_Q8;
            end
            return ((FLOOR_DB_Q8 - atten) * FULL_LEVEL + FLOOR_DB_Q8 / 2) / FLOOR_DB_Q8;
        endfunction

        // Record an accepted request: advance the bin's smoothed level, queue the result
        function void note_bin(logic [BIN_W-1:0] bin, logic [MAG_W-1:0] mag);
            level_result_t r;
            longint        lvl;
            longint        acc;
            lvl = level_of(mag);
            acc = longint'(smoothed_mem[bin]) * OLD_WEIGHT + lvl * NEW_WEIGHT + 32768;
            acc = acc >>> 16;
            if (acc > FULL_LEVEL)
                acc = FULL_LEVEL;
            smoothed_mem[bin] = LEVEL_W'(acc);
            r.bin      = bin;
            r.level    = LEVEL_W'(lvl);
            r.smoothed = LEVEL_W'(acc);
            pending_levels.push_back(r);
        endfunction

        // Compare one accepted result with the oldest queued one
        function void check_level(logic [BIN_W-1:0] bin, logic [LEVEL_W-1:0] lvl,
                                  logic [LEVEL_W-1:0] sm);
            level_result_t e;
            if (pending_levels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: bin %0d level %0d smoothed %0d",
                             bin, lvl, sm);
                return;
            end
            e = pending_levels.pop_front();
            if (bin !== e.bin || lvl !== e.level || sm !== e.smoothed)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch: bin %0d/%0d level %0d/%0d smoothed %0d/%0d (exp/act)",
                             e.bin, bin, e.level, lvl, e.smoothed, sm);
            end
        endfunction
    endclass

endpackage

[tb/tb.sv]
`timescale 1ns / 1ps
// Bench top for the spectrum dB level smoother: directed and random bin requests
// with random idling on both channels, results checked by the level tracker.
// Depends on sdbls_pkg, sdbls_in_if, sdbls_out_if, sdbls_level_tracker_pkg and the RTL.
module tb;
    import sdbls_pkg::*;
    import sdbls_level_tracker_pkg::*;

    localparam int STALL_LIMIT     = 4000;
    localparam int DRAIN_CYCLES    = 24;
    localparam int RANDOM_REQUESTS = 1330;
    localparam int IDLE_PCT        = 8;
    localparam int STEADY_FIRST    = 500;
    localparam int STEADY_LAST     = 800;

    logic clk;
    logic rst_n;
    logic steady;

    level_tracker tracker = new();

    sdbls_in_if  bin_req();
    sdbls_out_if level_req();

    spectrum_db_level_smoother_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .bin_req   (bin_req),
        .level_req (level_req)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Drop result ready now and then, except during the steady stretch
    initial
    begin
        level_req.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            level_req.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Check results and watch for a hung pipeline; sample at the falling edge
    initial
    begin : result_watch
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(negedge clk);
            if (level_req.valid === 1'b1 && level_req.ready === 1'b1)
                tracker.check_level(level_req.out_bin, level_req.level,
                                    level_req.smoothed_level);
            if ((bin_req.valid === 1'b1 && bin_req.ready === 1'b1) ||
                (level_req.valid === 1'b1 && level_req.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    // Offer one bin request, idling first now and then; hold until it is taken
    task automatic send_request(input logic [BIN_W-1:0] bin, input logic [MAG_W-1:0] mag);
        logic taken;
        if (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            bin_req.valid <= 1'b0;
            @(posedge clk);
        end
        bin_req.valid     <= 1'b1;
        bin_req.bin_index <= bin;
        bin_req.magnitude <= mag;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = (bin_req.ready === 1'b1);
            @(posedge clk);
        end
        tracker.note_bin(bin, mag);
    endtask

    initial
    begin : stimulus
        logic [BIN_W-1:0] b;
        logic [MAG_W-1:0] m;
        int               sent;
        int               burst;
        int               pick;
        rst_n             = 1'b0;
        steady            = 1'b0;
        bin_req.valid     = 1'b0;
        bin_req.bin_index = '0;
        bin_req.magnitude = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Zero, tiny, around the -100 dB floor, around full scale, max
        send_request(10'd0,    24'd0);
        send_request(10'd1023, 24'hFFFFFF);
        send_request(10'd1,    24'd1);
        send_request(10'd2,    24'd83);
        send_request(10'd3,    24'd84);
        send_request(10'd4,    24'd85);
        send_request(10'd5,    24'd255);
        send_request(10'd6,    24'd4096);
        send_request(10'h155,  24'h7FFFFF);
        send_request(10'h2AA,  24'h800000);
        send_request(10'd512,  24'hAAAAAA);
        send_request(10'd511,  24'h555555);
        // Hammer one bin back to back: rise toward full level, then decay
        repeat (8) send_request(10'd7, 24'hFFFFFF);
        repeat (4) send_request(10'd7, 24'd0);

        // Random part: favor a few hot bins and spread magnitudes over the dB span
        sent = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            steady = (sent >= STEADY_FIRST && sent < STEADY_LAST);
            if ($urandom_range(0, 99) < 30)
                b = BIN_W'($urandom_range(0, 3));
            else
                b = BIN_W'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 30)
                m = MAG_W'($urandom);
            else if (pick < 70)
                m = MAG_W'($urandom >> $urandom_range(8, 31));
            else if (pick < 85)
                m = MAG_W'($urandom_range(0, 100));
            else
                m = MAG_W'($urandom_range(24'h7FFF00, 24'h800100));
            // Repeat the same request now and then so the bin settles
            burst = ($urandom_range(0, 99) < 5) ? 8 : 1;
            repeat (burst) send_request(b, m);
            sent += burst;
        end
        steady = 1'b0;
        bin_req.valid <= 1'b0;

        // Drain outstanding results, then allow for any stray extra ones
        while (tracker.pending_levels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
rtl/core/sdbls_pkg.sv
rtl/core/sdbls_in_if.sv
rtl/core/sdbls_out_if.sv
rtl/core/sdbls_log2.sv
rtl/core/sdbls_level.sv
rtl/core/sdbls_smooth.sv
rtl/core/spectrum_db_level_smoother_unit.sv
tb/sdbls_level_tracker_pkg.sv
tb/tb.sv
